>>> hdl/cesd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_pkg
// Shared types and constants for the C escape sequence decoder.
// ----------------------------------------------------------------------------
package cesd_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int MAX_RES    = 4;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TRAIL   = 3'd1;
  localparam logic [2:0] ERR_HEX     = 3'd2;
  localparam logic [2:0] ERR_SHORT   = 3'd3;
  localparam logic [2:0] ERR_RANGE   = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN = 3'd5;

  localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;
  localparam logic [20:0] CP_1BYTE = 21'h00007F;
  localparam logic [20:0] CP_2BYTE = 21'h0007FF;
  localparam logic [20:0] CP_3BYTE = 21'h00FFFF;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_ESC  = 3'd1,
    M_HEX  = 3'd2,
    M_OCT  = 3'd3,
    M_UNI  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [2:0] err;
  } res_t;

  // one bundle of results caused by a single input word
  typedef struct packed {
    logic [2:0]               cnt;
    res_t [MAX_RES-1:0]       res;
  } entry_t;

  function automatic res_t mk_res(input logic [7:0] data, input logic valid,
                                  input logic [2:0] err);
    res_t r;
    r.data  = data;
    r.valid = valid;
    r.err   = err;
    return r;
  endfunction

endpackage

>>> hdl/cesd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_front
// Parser: accepts one string byte per cycle while the bundle queue is not full,
// tracks escape state and builds the bundle of results that byte causes.
// ----------------------------------------------------------------------------
module cesd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             end_of_string,
  input  logic             q_full,
  output logic             push,
  output cesd_pkg::entry_t push_entry
);
  import cesd_pkg::*;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BIG_U  = 8'h55;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic [8:0] simple_map(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    unique case (c)
      8'h6E:   r = {1'b1, 8'h0A};
      8'h74:   r = {1'b1, 8'h09};
      8'h72:   r = {1'b1, 8'h0D};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h76:   r = {1'b1, 8'h0B};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      8'h3F:   r = {1'b1, 8'h3F};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  mode_t       mode, mode_next;
  logic [31:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic        long_u, long_next;
  logic        skip, skip_next;

  entry_t      ent;
  logic [2:0]  k;
  logic [2:0]  err;
  logic        redo;
  logic [4:0]  hx;
  logic [8:0]  sm;
  logic        is_oct;
  logic [31:0] uni_acc;
  logic [3:0]  uni_cnt;
  logic [3:0]  need;
  logic [7:0]  oct_acc;
  logic [20:0] cp;
  logic        accept;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign push       = accept && (k != 3'd0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      acc    <= '0;
      cnt    <= '0;
      long_u <= 1'b0;
      skip   <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      acc    <= acc_next;
      cnt    <= cnt_next;
      long_u <= long_next;
      skip   <= skip_next;
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    long_next = long_u;
    skip_next = skip;
    ent       = '0;
    k         = 3'd0;
    err       = ERR_NONE;
    redo      = 1'b0;
    hx        = hex_val(in_byte);
    sm        = simple_map(in_byte);
    is_oct    = (in_byte >= 8'h30) && (in_byte <= 8'h37);
    uni_acc   = {acc[27:0], hx[3:0]};
    uni_cnt   = cnt + 4'd1;
    need      = long_u ? 4'd8 : 4'd4;
    oct_acc   = {acc[4:0], in_byte[2:0]};
    cp        = uni_acc[20:0];

    if (skip) begin
      if (end_of_string) begin
        skip_next = 1'b0;
        mode_next = M_IDLE;
        acc_next  = '0;
        cnt_next  = '0;
        long_next = 1'b0;
      end
    end else begin
      unique case (mode)
        M_IDLE: redo = 1'b1;
        M_ESC: begin
          if (sm[8]) begin
            ent.res[k[1:0]] = mk_res(sm[7:0], 1'b1, ERR_NONE);
            k = k + 3'd1;
            mode_next = M_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
            long_next = 1'b0;
          end else if (in_byte == CH_X) begin
            mode_next = M_HEX;
            acc_next  = '0;
            cnt_next  = '0;
            long_next = 1'b0;
          end else if (in_byte == CH_U || in_byte == CH_BIG_U) begin
            mode_next = M_UNI;
            acc_next  = '0;
            cnt_next  = '0;
            long_next = (in_byte == CH_BIG_U);
          end else if (is_oct) begin
            mode_next = M_OCT;
            acc_next  = {29'd0, in_byte[2:0]};
            cnt_next  = 4'd1;
          end else begin
            err = ERR_UNKNOWN;
          end
        end
        M_HEX: begin
          if (hx[4]) begin
            acc_next = {24'd0, acc[3:0], hx[3:0]};
            if (cnt != 4'd15) cnt_next = cnt + 4'd1;
          end else if (cnt == 4'd0) begin
            err = ERR_HEX;
          end else begin
            ent.res[k[1:0]] = mk_res(acc[7:0], 1'b1, ERR_NONE);
            k = k + 3'd1;
            mode_next = M_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
            long_next = 1'b0;
            redo      = 1'b1;
          end
        end
        M_OCT: begin
          if (is_oct) begin
            acc_next = {24'd0, oct_acc};
            cnt_next = cnt + 4'd1;
            if (cnt + 4'd1 >= 4'd3) begin
              ent.res[k[1:0]] = mk_res(oct_acc, 1'b1, ERR_NONE);
              k = k + 3'd1;
              mode_next = M_IDLE;
              acc_next  = '0;
              cnt_next  = '0;
              long_next = 1'b0;
            end
          end else begin
            ent.res[k[1:0]] = mk_res(acc[7:0], 1'b1, ERR_NONE);
            k = k + 3'd1;
            mode_next = M_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
            long_next = 1'b0;
            redo      = 1'b1;
          end
        end
        M_UNI: begin
          if (!hx[4]) begin
            err = ERR_SHORT;
          end else begin
            acc_next = uni_acc;
            cnt_next = uni_cnt;
            if (uni_cnt >= need) begin
              if (uni_acc > CP_MAX) begin
                err = ERR_RANGE;
              end else begin
                if (cp <= CP_1BYTE) begin
                  ent.res[0] = mk_res(cp[7:0], 1'b1, ERR_NONE);
                  k = 3'd1;
                end else if (cp <= CP_2BYTE) begin
                  ent.res[0] = mk_res({3'b110, cp[10:6]}, 1'b1, ERR_NONE);
                  ent.res[1] = mk_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
                  k = 3'd2;
                end else if (cp <= CP_3BYTE) begin
                  ent.res[0] = mk_res({4'b1110, cp[15:12]}, 1'b1, ERR_NONE);
                  ent.res[1] = mk_res({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
                  ent.res[2] = mk_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
                  k = 3'd3;
                end else begin
                  ent.res[0] = mk_res({5'b11110, cp[20:18]}, 1'b1, ERR_NONE);
                  ent.res[1] = mk_res({2'b10, cp[17:12]}, 1'b1, ERR_NONE);
                  ent.res[2] = mk_res({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
                  ent.res[3] = mk_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
                  k = 3'd4;
                end
                mode_next = M_IDLE;
                acc_next  = '0;
                cnt_next  = '0;
                long_next = 1'b0;
              end
            end
          end
        end
        default: mode_next = M_IDLE;
      endcase

      // idle bytes and a byte that ended a digit run are decoded as plain text or open an escape
      if (redo) begin
        if (in_byte == CH_BSLASH) begin
          mode_next = M_ESC;
        end else begin
          ent.res[k[1:0]] = mk_res(in_byte, 1'b1, ERR_NONE);
          k = k + 3'd1;
        end
      end

      if (err == ERR_NONE && end_of_string) begin
        unique case (mode_next)
          M_ESC: err = ERR_TRAIL;
          M_HEX: begin
            if (cnt_next == 4'd0) begin
              err = ERR_HEX;
            end else begin
              ent.res[k[1:0]] = mk_res(acc_next[7:0], 1'b1, ERR_NONE);
              k = k + 3'd1;
            end
          end
          M_OCT: begin
            ent.res[k[1:0]] = mk_res(acc_next[7:0], 1'b1, ERR_NONE);
            k = k + 3'd1;
          end
          M_UNI:   err = ERR_SHORT;
          default: ;
        endcase
      end

      if (err != ERR_NONE) begin
        ent.res[k[1:0]] = mk_res(8'h00, 1'b0, err);
        k = k + 3'd1;
        skip_next = !end_of_string;
        mode_next = M_IDLE;
        acc_next  = '0;
        cnt_next  = '0;
        long_next = 1'b0;
      end else if (end_of_string) begin
        mode_next = M_IDLE;
        acc_next  = '0;
        cnt_next  = '0;
        long_next = 1'b0;
      end
    end
    ent.cnt = k;
  end

endmodule

>>> hdl/cesd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_fifo
// Small register queue of result bundles between parser and serializer.
// ----------------------------------------------------------------------------
module cesd_fifo #(
  parameter int DEPTH = cesd_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cesd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output cesd_pkg::entry_t head,
  output logic             head_valid
);
  import cesd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

>>> hdl/cesd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesd_back
// Serializer: while the output register is free, walks the head bundle one
// result per cycle into it and pops the bundle with its last result.
// ----------------------------------------------------------------------------
module cesd_back (
  input  logic             clk,
  input  logic             rst,
  input  cesd_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output cesd_pkg::res_t   out_res,
  output logic             out_last
);
  import cesd_pkg::*;

  logic [1:0] idx;
  logic       out_free;
  logic       at_last;

  assign out_free = !out_valid || out_ready;
  assign at_last  = ({1'b0, idx} == head.cnt - 3'd1);
  assign pop      = out_free && head_valid && at_last;

  always_ff @(posedge clk) begin
    if (out_free && head_valid) begin
      out_res  <= head.res[idx];
      out_last <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (out_free) begin
      out_valid <= head_valid;
      if (head_valid) idx <= at_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

>>> hdl/c_escape_sequence_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// Decodes C string escapes (simple, hex, octal, \u and \U to UTF-8).
// An accepted byte's bundle is queued; its first result word is then registered for output.
// Throughput: one input byte per cycle; results leave one word per cycle
// from the serializer while the output is free, so a 2-4 byte UTF-8 sequence
// holds input only once the bundle queue (FIFO_DEPTH entries) has filled.
// Reset: synchronous, clears parser state, queue pointers and output valid.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder #(
  parameter int FIFO_DEPTH = cesd_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] byte_valid, [11:9] error_code
  output logic        m_axis_tlast    // last_of_run
);
  import cesd_pkg::*;

  entry_t push_entry, head;
  logic   push, q_full, pop, head_valid;
  res_t   out_res;

  cesd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_byte       (s_axis_tdata),
    .end_of_string (s_axis_tlast),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  cesd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  cesd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_res.err, out_res.valid, out_res.data};

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_res.err != ERR_NONE) |-> m_axis_tlast)
    else $error("error result not last of its run");

  a_valid_xor_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_res.valid != (out_res.err != ERR_NONE)))
    else $error("result is neither a byte nor an error");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_entry.cnt != 3'd0) && (push_entry.cnt <= 3'd4))
    else $error("bundle result count out of range");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && (head.cnt != 3'd0))
    else $error("pop without a valid bundle");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for c_escape_sequence_decoder. A short directed table of
// characters is followed by random strings built from escape fragments. Each
// accepted character runs through a local decoder model. The model's output
// words, or a row's typed-in result, are queued and compared field by field with every output word.
// ----------------------------------------------------------------------------
module testbench;
  import cesd_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_CHARS = 300;
  localparam logic [87:0] SIMPLE_ESC = "ntrabfv\\'\"?";

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [2:0] err;
    logic       last;
  } out_word_t;

  // one input character, with an optional typed-in single result
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       typed;
    logic [7:0] data;
    logic       valid;
    logic [2:0] err;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tlast;   // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] out_byte, [8] byte_valid, [11:9] error_code
  logic        m_axis_tlast;   // last_of_run

  c_escape_sequence_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder model state
  mode_t       esc_mode  = M_IDLE;
  logic [31:0] digit_acc = '0;
  logic [3:0]  digit_cnt = '0;
  logic        long_u    = 1'b0;
  logic        skipping  = 1'b0;

  out_word_t   step_words[$];
  out_word_t   decoded_q[$];
  text_item_t  text_q[$];
  logic [7:0]  str_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  function automatic text_item_t pass_row(input logic [7:0] ch, input logic eos);
    text_item_t t;
    t = '0;
    t.ch  = ch;
    t.eos = eos;
    return t;
  endfunction

  function automatic text_item_t check_row(input logic [7:0] ch, input logic eos,
                                           input logic [7:0] data, input logic valid,
                                           input logic [2:0] err);
    text_item_t t;
    t.ch    = ch;
    t.eos   = eos;
    t.typed = 1'b1;
    t.data  = data;
    t.valid = valid;
    t.err   = err;
    return t;
  endfunction

  function automatic int hex_nib(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0") + 8'(n);
    if ($urandom_range(0, 1) == 0) return 8'("a") + 8'(n) - 8'd10;
    return 8'("A") + 8'(n) - 8'd10;
  endfunction

  task automatic push_word(input logic [7:0] data, input logic valid, input logic [2:0] err);
    out_word_t w;
    w.data  = data;
    w.valid = valid;
    w.err   = err;
    w.last  = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic go_idle();
    esc_mode  = M_IDLE;
    digit_acc = '0;
    digit_cnt = '0;
    long_u    = 1'b0;
  endtask

  // advance the model by one character; words land in step_words
  task automatic decode_char(input logic [7:0] b, input logic eos);
    int         d;
    logic [2:0] code;
    bit         again;
    code  = ERR_NONE;
    again = 1'b1;
    step_words.delete();
    if (skipping) begin
      if (eos) begin
        skipping = 1'b0;
        go_idle();
      end
    end else begin
      while (again) begin
        again = 1'b0;
        case (esc_mode)
          M_ESC: begin
            case (b)
              "n":     d = 'h0A;
              "t":     d = 'h09;
              "r":     d = 'h0D;
              "a":     d = 'h07;
              "b":     d = 'h08;
              "f":     d = 'h0C;
              "v":     d = 'h0B;
              "\\":    d = 'h5C;
              "'":     d = 'h27;
              "\"":    d = 'h22;
              "?":     d = 'h3F;
              default: d = -1;
            endcase
            if (d >= 0) begin
              push_word(d[7:0], 1'b1, ERR_NONE);
              go_idle();
            end else if (b == "x") begin
              go_idle();
              esc_mode = M_HEX;
            end else if (b == "u" || b == "U") begin
              go_idle();
              esc_mode = M_UNI;
              long_u   = (b == "U");
            end else if (b >= "0" && b <= "7") begin
              esc_mode  = M_OCT;
              digit_acc = {29'b0, b[2:0]};
              digit_cnt = 4'd1;
            end else begin
              code = ERR_UNKNOWN;
            end
          end
          M_HEX: begin
            d = hex_nib(b);
            if (d >= 0) begin
              digit_acc = {24'b0, digit_acc[3:0], d[3:0]};
              if (digit_cnt < 4'd15) digit_cnt = digit_cnt + 4'd1;
            end else if (digit_cnt == 0) begin
              code = ERR_HEX;
            end else begin
              push_word(digit_acc[7:0], 1'b1, ERR_NONE);
              go_idle();
              again = 1'b1;
            end
          end
          M_OCT: begin
            if (b >= "0" && b <= "7") begin
              digit_acc = {24'b0, digit_acc[4:0], b[2:0]};
              digit_cnt = digit_cnt + 4'd1;
              if (digit_cnt >= 4'd3) begin
                push_word(digit_acc[7:0], 1'b1, ERR_NONE);
                go_idle();
              end
            end else begin
              push_word(digit_acc[7:0], 1'b1, ERR_NONE);
              go_idle();
              again = 1'b1;
            end
          end
          M_UNI: begin
            d = hex_nib(b);
            if (d < 0) begin
              code = ERR_SHORT;
            end else begin
              digit_acc = {digit_acc[27:0], d[3:0]};
              digit_cnt = digit_cnt + 4'd1;
              if (digit_cnt >= (long_u ? 4'd8 : 4'd4)) begin
                if (digit_acc > CP_MAX) begin
                  code = ERR_RANGE;
                end else begin
                  if (digit_acc <= 32'(CP_1BYTE)) begin
                    push_word(digit_acc[7:0], 1'b1, ERR_NONE);
                  end else if (digit_acc <= 32'(CP_2BYTE)) begin
                    push_word({3'b110, digit_acc[10:6]}, 1'b1, ERR_NONE);
                    push_word({2'b10, digit_acc[5:0]}, 1'b1, ERR_NONE);
                  end else if (digit_acc <= 32'(CP_3BYTE)) begin
                    push_word({4'b1110, digit_acc[15:12]}, 1'b1, ERR_NONE);
                    push_word({2'b10, digit_acc[11:6]}, 1'b1, ERR_NONE);
                    push_word({2'b10, digit_acc[5:0]}, 1'b1, ERR_NONE);
                  end else begin
                    push_word({5'b11110, digit_acc[20:18]}, 1'b1, ERR_NONE);
                    push_word({2'b10, digit_acc[17:12]}, 1'b1, ERR_NONE);
                    push_word({2'b10, digit_acc[11:6]}, 1'b1, ERR_NONE);
                    push_word({2'b10, digit_acc[5:0]}, 1'b1, ERR_NONE);
                  end
                  go_idle();
                end
              end
            end
          end
          default: begin
            if (b == "\\") esc_mode = M_ESC;
            else push_word(b, 1'b1, ERR_NONE);
          end
        endcase
      end

      if (code == ERR_NONE && eos) begin
        if (esc_mode == M_ESC) code = ERR_TRAIL;
        else if (esc_mode == M_HEX && digit_cnt == 0) code = ERR_HEX;
        else if (esc_mode == M_HEX || esc_mode == M_OCT)
          push_word(digit_acc[7:0], 1'b1, ERR_NONE);
        else if (esc_mode == M_UNI) code = ERR_SHORT;
      end

      if (code != ERR_NONE) begin
        push_word(8'h00, 1'b0, code);
        skipping = !eos;
        go_idle();
      end else if (eos) begin
        go_idle();
      end
    end
  endtask

  // random string built from escape fragments; sometimes cut short
  task automatic add_string();
    int          nseg;
    int          kind;
    int          nd;
    logic [31:0] cp;
    logic [7:0]  c;
    str_q.delete();
    nseg = $urandom_range(1, 6);
    repeat (nseg) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        c = 8'($urandom_range(0, 255));
        if (c == "\\") c = "A";
        str_q.push_back(c);
      end else if (kind < 32) begin
        str_q.push_back("\\");
        str_q.push_back(SIMPLE_ESC[8 * $urandom_range(0, 10) +: 8]);
      end else if (kind < 47) begin
        str_q.push_back("\\");
        str_q.push_back("x");
        if ($urandom_range(0, 7) == 0) nd = $urandom_range(10, 20);
        else if ($urandom_range(0, 9) == 0) nd = 0;
        else nd = $urandom_range(1, 3);
        repeat (nd) str_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end else if (kind < 60) begin
        str_q.push_back("\\");
        nd = $urandom_range(1, 4);
        repeat (nd) str_q.push_back(8'("0") + 8'($urandom_range(0, 7)));
      end else if (kind < 90) begin
        str_q.push_back("\\");
        if (kind < 75) begin
          str_q.push_back("u");
          nd = 4;
          case ($urandom_range(0, 3))
            0:       cp = $urandom_range(0, 'h7F);
            1:       cp = $urandom_range('h80, 'h7FF);
            2:       cp = $urandom_range('h800, 'hFFFF);
            default: cp = $urandom_range('hD800, 'hDFFF);
          endcase
        end else begin
          str_q.push_back("U");
          nd = 8;
          case ($urandom_range(0, 4))
            0:       cp = $urandom_range(0, 'hFFFF);
            1:       cp = $urandom_range('h10000, 'h10FFFF);
            2:       cp = CP_MAX;
            3:       cp = CP_MAX + 1;
            default: cp = $urandom;
          endcase
        end
        for (int i = nd - 1; i >= 0; i--) str_q.push_back(hex_char(cp[4 * i +: 4]));
      end else begin
        str_q.push_back("\\");
        str_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      nd = $urandom_range(1, 3);
      while (nd > 0 && str_q.size() > 1) begin
        void'(str_q.pop_back());
        nd--;
      end
    end
    for (int i = 0; i < str_q.size(); i++)
      text_q.push_back(pass_row(str_q[i], i == str_q.size() - 1));
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // stimulus
  initial begin
    int         gap;
    int         quiet;
    int         ndir;
    text_item_t t;
    out_word_t  w;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    quiet = 0;

    text_q = '{
      check_row(8'h00, 1'b1, 8'h00, 1'b1, ERR_NONE),
      check_row(8'hFF, 1'b0, 8'hFF, 1'b1, ERR_NONE),
      pass_row ("\\",  1'b0),
      check_row("\"",  1'b0, 8'h22, 1'b1, ERR_NONE),
      pass_row ("\\",  1'b0),
      pass_row ("x",   1'b0),
      pass_row ("4",   1'b0),
      pass_row ("1",   1'b0),
      pass_row ("\\",  1'b0),
      pass_row ("7",   1'b0),
      pass_row ("7",   1'b0),
      check_row("7",   1'b0, 8'hFF, 1'b1, ERR_NONE),
      pass_row ("\\",  1'b0),
      pass_row ("u",   1'b0),
      pass_row ("D",   1'b0),
      pass_row ("8",   1'b0),
      pass_row ("0",   1'b0),
      pass_row ("0",   1'b0),
      pass_row ("\\",  1'b0),
      pass_row ("x",   1'b0),
      check_row("q",   1'b0, 8'h00, 1'b0, ERR_HEX),
      pass_row ("A",   1'b1),
      pass_row ("\\",  1'b0),
      pass_row ("u",   1'b0),
      check_row("1",   1'b1, 8'h00, 1'b0, ERR_SHORT),
      pass_row ("\\",  1'b0),
      check_row("5",   1'b1, 8'h05, 1'b1, ERR_NONE),
      pass_row ("\\",  1'b0),
      check_row("k",   1'b0, 8'h00, 1'b0, ERR_UNKNOWN),
      pass_row ("\\",  1'b1),
      check_row("\\",  1'b1, 8'h00, 1'b0, ERR_TRAIL)
    };
    ndir = text_q.size();
    while (text_q.size() < ndir + RANDOM_CHARS) add_string();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < text_q.size(); i++) begin
      t = text_q[i];
      if (quiet > 0) begin
        gap = 0;
        quiet--;
      end else begin
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 7) == 0) quiet = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= t.ch;
      s_axis_tlast  <= t.eos;
      do @(posedge clk); while (!s_axis_tready);
      decode_char(t.ch, t.eos);
      if (t.typed) begin
        w.data  = t.data;
        w.valid = t.valid;
        w.err   = t.err;
        w.last  = 1'b1;
        decoded_q.push_back(w);
      end else begin
        for (int k = 0; k < step_words.size(); k++) begin
          w      = step_words[k];
          w.last = (k == step_words.size() - 1);
          decoded_q.push_back(w);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // output side
  initial begin
    int        gap;
    int        quiet;
    out_word_t want;
    m_axis_tready <= 1'b0;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet > 0) begin
        gap = 0;
        quiet--;
      end else begin
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 7) == 0) quiet = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (decoded_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata[7:0] !== want.data)
          flag_mismatch($sformatf("out_byte %h, want %h", m_axis_tdata[7:0], want.data));
        if (m_axis_tdata[8] !== want.valid)
          flag_mismatch($sformatf("byte_valid %b, want %b", m_axis_tdata[8], want.valid));
        if (m_axis_tdata[11:9] !== want.err)
          flag_mismatch($sformatf("error_code %0d, want %0d", m_axis_tdata[11:9], want.err));
        if (m_axis_tlast !== want.last)
          flag_mismatch($sformatf("last_of_run %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
